[rtl/gfcc_pkg.sv]
`default_nettype none

package gfcc_pkg;

  // fixed-point layout of positions and trig values
  localparam int FRAC      = 14;
  localparam int POS_W     = 26;
  localparam int TRIG_W    = 16;
  localparam int PROD_W    = TRIG_W + 9;
  localparam int POSE_W    = 16;
  localparam int HEADING_W = 10;
  localparam int COORD_W   = 8;
  localparam int VALUE_W   = 8;

  // angle constants in Q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BODY_LENGTH = 3'd0,
    REG_HALF_WIDTH  = 3'd1,
    REG_REAR_OFFSET = 3'd2,
    REG_THRESHOLD   = 3'd3,
    REG_MAP_WIDTH   = 3'd4,
    REG_MAP_HEIGHT  = 3'd5,
    REG_OUTSIDE     = 3'd6
  } cfg_reg_t;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_OBSTACLE = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] body_length;
    logic [6:0] half_width;
    logic [7:0] rear_offset;
    logic [7:0] threshold;
    logic [8:0] map_width;
    logic [8:0] map_height;
    logic       outside_is_obstacle;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [TRIG_W-1:0] sin_v;
    logic [TRIG_W-1:0] cos_v;
  } trig_t;

  typedef struct packed {
    logic    busy;
    logic    done;
    status_t status;
  } scan_res_t;

endpackage

`default_nettype wire

[rtl/gfcc_trig.sv]
`default_nettype none

module gfcc_trig #(
  parameter int ANGLE_STEPS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [gfcc_pkg::HEADING_W-1:0]  heading,
  output gfcc_pkg::trig_t                 trig
);
  import gfcc_pkg::*;

  localparam int AW  = $clog2(ANGLE_STEPS);
  localparam int QTR = ANGLE_STEPS / 4;
  localparam int QW  = AW - 2;

  typedef logic [14:0] rom_t [QTR];

  // sine of a first-quadrant angle in q30, odd taylor terms up to x^11
  function automatic logic [14:0] sin_quarter(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    if (sum <= 0) return 15'd0;
    sum = longint'(($unsigned(sum) + 64'd32768) >> 16);
    if (sum > 16384) sum = 16384;
    return sum[14:0];
  endfunction

  function automatic rom_t build_rom(input bit cosine);
    rom_t            r;
    longint unsigned th;
    for (int j = 0; j < QTR; j++) begin
      th = (longint'(j) * TWO_PI_Q30) / ANGLE_STEPS;
      r[j] = cosine ? sin_quarter(HALF_PI_Q30 - th) : sin_quarter(th);
    end
    return r;
  endfunction

  localparam rom_t SIN_ROM = build_rom(1'b0);
  localparam rom_t COS_ROM = build_rom(1'b1);

  logic [HEADING_W+AW-1:0] head_ext;
  logic [AW-1:0]           code;
  logic [1:0]              quad1, quad2;
  logic [QW-1:0]           idx1;
  logic [14:0]             sin_rd, cos_rd;
  logic                    v1, v2, v3;
  logic [TRIG_W-1:0]       a_ext, b_ext;
  logic [TRIG_W-1:0]       sin_q, cos_q;
  logic [TRIG_W-1:0]       sin_next, cos_next;

  // heading taken modulo the number of angle steps
  assign head_ext = {{AW{1'b0}}, heading};
  assign code     = head_ext[AW-1:0];

  assign a_ext = {1'b0, sin_rd};
  assign b_ext = {1'b0, cos_rd};

  always_comb begin
    case (quad2)
      2'd0: begin
        sin_next = a_ext;
        cos_next = b_ext;
      end
      2'd1: begin
        sin_next = b_ext;
        cos_next = -a_ext;
      end
      2'd2: begin
        sin_next = -a_ext;
        cos_next = -b_ext;
      end
      default: begin
        sin_next = -b_ext;
        cos_next = a_ext;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
    if (start) begin
      quad1 <= code[AW-1:AW-2];
      idx1  <= code[QW-1:0];
    end
    sin_rd <= SIN_ROM[idx1];
    cos_rd <= COS_ROM[idx1];
    quad2  <= quad1;
    sin_q  <= sin_next;
    cos_q  <= cos_next;
  end

  assign trig.valid = v3;
  assign trig.sin_v = sin_q;
  assign trig.cos_v = cos_q;

endmodule

`default_nettype wire

[rtl/gfcc_map_mem.sv]
`default_nettype none

module gfcc_map_mem #(
  parameter int MAP_SIDE       = 256,
  parameter int OCCUPANCY_BITS = 8
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [2*$clog2(MAP_SIDE)-1:0]   wr_addr,
  input  logic [OCCUPANCY_BITS-1:0]       wr_data,
  input  logic                            rd_en,
  input  logic [2*$clog2(MAP_SIDE)-1:0]   rd_addr,
  output logic [OCCUPANCY_BITS-1:0]       rd_data
);

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;

  logic [OCCUPANCY_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/gfcc_walker.sv]
`default_nettype none

module gfcc_walker #(
  parameter int MAP_SIDE       = 256,
  parameter int OCCUPANCY_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [gfcc_pkg::POSE_W-1:0]     pose_x,
  input  logic [gfcc_pkg::POSE_W-1:0]     pose_y,
  input  gfcc_pkg::cfg_t                  cfg,
  input  gfcc_pkg::trig_t                 trig,
  output logic                            rd_en,
  output logic [2*$clog2(MAP_SIDE)-1:0]   rd_addr,
  input  logic [OCCUPANCY_BITS-1:0]       rd_data,
  output gfcc_pkg::scan_res_t             res,
  input  logic                            res_ack
);
  import gfcc_pkg::*;

  localparam int SB    = $clog2(MAP_SIDE);
  localparam int IX_W  = POS_W - 1 - FRAC;
  localparam int CMP_W = ((SB + 1) > IX_W) ? (SB + 1) : IX_W;
  localparam int CW    = (OCCUPANCY_BITS > VALUE_W) ? OCCUPANCY_BITS : VALUE_W;

  typedef enum logic [5:0] {
    W_IDLE  = 6'b000001,
    W_TRIG  = 6'b000010,
    W_SETUP = 6'b000100,
    W_WALK  = 6'b001000,
    W_DRAIN = 6'b010000,
    W_DONE  = 6'b100000
  } walk_state_t;

  walk_state_t state, state_next;

  logic [POSE_W-1:0] px, py;
  logic [POS_W-1:0]  s_ext, c_ext;
  logic [PROD_W-1:0] prod_c, prod_s;
  logic [POS_W-1:0]  vx, vy, lx, ly, rx, ry;
  logic [POS_W-1:0]  base_x, base_y;
  logic [POS_W-1:0]  pt_x, pt_y;
  logic [7:0]        row;
  logic [6:0]        col;
  logic              side;
  logic              last_pt;
  logic [CMP_W-1:0]  ix, iy;
  logic              outside_now;
  logic              chk_valid, chk_outside;
  logic              obstacle, hit_now;
  status_t           hit_status, status;

  // start of the footprint: pose moved back by the rear offset
  assign base_x = {{(POS_W-POSE_W-6){1'b0}}, px, 6'b0}
                - {{(POS_W-PROD_W){prod_c[PROD_W-1]}}, prod_c};
  assign base_y = {{(POS_W-POSE_W-6){1'b0}}, py, 6'b0}
                - {{(POS_W-PROD_W){prod_s[PROD_W-1]}}, prod_s};

  // current probe point, left before right
  assign pt_x = side ? rx : lx;
  assign pt_y = side ? ry : ly;
  assign ix   = CMP_W'(pt_x[POS_W-2:FRAC]);
  assign iy   = CMP_W'(pt_y[POS_W-2:FRAC]);

  assign outside_now = pt_x[POS_W-1] | pt_y[POS_W-1]
                     | (ix >= CMP_W'(cfg.map_width))  | (ix >= CMP_W'(MAP_SIDE))
                     | (iy >= CMP_W'(cfg.map_height)) | (iy >= CMP_W'(MAP_SIDE));

  assign rd_en   = (state == W_WALK) && !outside_now;
  assign rd_addr = {ix[SB-1:0], iy[SB-1:0]};

  assign last_pt = side && (col == cfg.half_width) && (row == cfg.body_length);

  assign obstacle   = CW'(rd_data) > CW'(cfg.threshold);
  assign hit_now    = chk_valid && (chk_outside || obstacle);
  assign hit_status = chk_outside ? ST_OUTSIDE : ST_OBSTACLE;

  always_comb begin
    state_next = state;
    case (state)
      W_IDLE:  if (start) state_next = W_TRIG;
      W_TRIG:  if (trig.valid) state_next = W_SETUP;
      W_SETUP: state_next = W_WALK;
      W_WALK: begin
        if (hit_now) state_next = W_DONE;
        else if (outside_now || last_pt) state_next = W_DRAIN;
      end
      W_DRAIN: state_next = W_DONE;
      W_DONE:  if (res_ack) state_next = W_IDLE;
      default: state_next = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= W_IDLE;
      chk_valid <= 1'b0;
    end else begin
      state     <= state_next;
      chk_valid <= (state == W_WALK);
    end

    if (state == W_IDLE && start) begin
      px <= pose_x;
      py <= pose_y;
    end

    if (state == W_TRIG && trig.valid) begin
      s_ext  <= {{(POS_W-TRIG_W){trig.sin_v[TRIG_W-1]}}, trig.sin_v};
      c_ext  <= {{(POS_W-TRIG_W){trig.cos_v[TRIG_W-1]}}, trig.cos_v};
      prod_c <= PROD_W'($signed({1'b0, cfg.rear_offset}) * $signed(trig.cos_v));
      prod_s <= PROD_W'($signed({1'b0, cfg.rear_offset}) * $signed(trig.sin_v));
    end

    if (state == W_SETUP) begin
      vx   <= base_x;
      vy   <= base_y;
      lx   <= base_x;
      ly   <= base_y;
      rx   <= base_x;
      ry   <= base_y;
      row  <= '0;
      col  <= '0;
      side <= 1'b0;
    end else if (state == W_WALK) begin
      chk_outside <= outside_now;
      if (!side) begin
        side <= 1'b1;
      end else begin
        side <= 1'b0;
        if (col == cfg.half_width) begin
          // next row along the heading
          col <= '0;
          row <= row + 8'd1;
          vx  <= vx + c_ext;
          vy  <= vy + s_ext;
          lx  <= vx + c_ext;
          ly  <= vy + s_ext;
          rx  <= vx + c_ext;
          ry  <= vy + s_ext;
        end else begin
          col <= col + 7'd1;
          lx  <= lx - s_ext;
          ly  <= ly + c_ext;
          rx  <= rx + s_ext;
          ry  <= ry - c_ext;
        end
      end
    end

    if ((state == W_WALK || state == W_DRAIN) && state_next == W_DONE) begin
      status <= hit_now ? hit_status : ST_FREE;
    end
  end

  assign res.busy   = (state != W_IDLE);
  assign res.done   = (state == W_DONE);
  assign res.status = status;

  // a query only starts from idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == W_IDLE)
    else $error("query started while walker busy");

  // an outside point seen at the check stage ends the walk at once
  a_outside_stops: assert property (@(posedge clk) disable iff (rst)
    chk_valid && chk_outside && state == W_WALK |=> state == W_DONE && !rd_en)
    else $error("walk went on after an outside point");

  // the result stays put until it is taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res.done && !res_ack |=> res.done && $stable(res.status))
    else $error("walker result changed before it was taken");

endmodule

`default_nettype wire

[rtl/grid_footprint_collision_check.sv]
`default_nettype none

// occupancy grid footprint collision check. a MAP_SIDE x MAP_SIDE grid of
// OCCUPANCY_BITS cells sits in one single-port-read synchronous ram (cell
// x*MAP_SIDE+y). a load transaction (req_type 0) writes one cell in the
// cycle it is accepted and returns status 0; loads outside the grid are
// dropped. a query transaction (req_type 1) takes a rear-axle pose in q8.8
// cells and a heading code, looks up sine and cosine in a q2.14 quarter-wave
// rom, steps back by the rear offset and walks the footprint row by row,
// left point then right point per column, stopping at the first obstacle
// (status 1) or the first point off the map (status 2, collision set by
// outside_is_obstacle). the ram has no reset and no clearing pass: cells
// must be loaded before a query can read them. a query stalls the input
// through the trig lookup, the setup and the walk over every probed point,
// since the walk issues one map read per cycle into the one read port, and
// until its result is taken into the output register. one item is in flight
// at a time; the next item is accepted only when the output register is
// empty or being drained. configuration is written through
// cfg_write/cfg_index/cfg_data and must only change while idle.

module grid_footprint_collision_check #(
  parameter int MAP_SIDE       = 256,
  parameter int OCCUPANCY_BITS = 8,
  parameter int ANGLE_STEPS    = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // item channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic [gfcc_pkg::COORD_W-1:0]      cell_x,
  input  logic [gfcc_pkg::COORD_W-1:0]      cell_y,
  input  logic [gfcc_pkg::VALUE_W-1:0]      cell_value,
  input  logic [gfcc_pkg::POSE_W-1:0]       pose_x,
  input  logic [gfcc_pkg::POSE_W-1:0]       pose_y,
  input  logic [gfcc_pkg::HEADING_W-1:0]    heading,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic                              collision,
  // configuration
  input  logic                              cfg_write,
  input  logic [gfcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gfcc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gfcc_pkg::*;

  localparam int SB = $clog2(MAP_SIDE);
  localparam int AB = 2 * SB;
  localparam int EW = ((SB > COORD_W) ? SB : COORD_W) + 1;
  localparam int VW = (OCCUPANCY_BITS > VALUE_W) ? OCCUPANCY_BITS : VALUE_W;

  cfg_t       cfg;
  trig_t      trig;
  scan_res_t  res;

  logic                      in_take;
  logic                      out_free;
  logic                      load_take, query_take;
  logic [EW-1:0]             cx_ext, cy_ext;
  logic                      load_in_grid;
  logic [VW-1:0]             val_ext;
  logic                      wr_en;
  logic [AB-1:0]             wr_addr;
  logic [OCCUPANCY_BITS-1:0] wr_data;
  logic                      rd_en;
  logic [AB-1:0]             rd_addr;
  logic [OCCUPANCY_BITS-1:0] rd_data;
  logic                      res_ack;
  logic                      res_collision;

  // output register is free when empty or being drained this cycle
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = res.busy || !out_free;
  assign in_take    = in_valid && !in_stall;
  assign load_take  = in_take && (req_type == REQ_LOAD);
  assign query_take = in_take && (req_type == REQ_QUERY);

  // load address and data
  assign cx_ext       = EW'(cell_x);
  assign cy_ext       = EW'(cell_y);
  assign load_in_grid = (cx_ext < EW'(MAP_SIDE)) && (cy_ext < EW'(MAP_SIDE));
  assign val_ext      = VW'(cell_value);
  assign wr_en        = load_take && load_in_grid;
  assign wr_addr      = {cx_ext[SB-1:0], cy_ext[SB-1:0]};
  assign wr_data      = val_ext[OCCUPANCY_BITS-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.body_length         <= 8'd25;
      cfg.half_width          <= 7'd5;
      cfg.rear_offset         <= 8'd5;
      cfg.threshold           <= 8'd128;
      cfg.map_width           <= 9'd256;
      cfg.map_height          <= 9'd256;
      cfg.outside_is_obstacle <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_BODY_LENGTH: cfg.body_length         <= cfg_data[7:0];
        REG_HALF_WIDTH:  cfg.half_width          <= cfg_data[6:0];
        REG_REAR_OFFSET: cfg.rear_offset         <= cfg_data[7:0];
        REG_THRESHOLD:   cfg.threshold           <= cfg_data[7:0];
        REG_MAP_WIDTH:   cfg.map_width           <= cfg_data;
        REG_MAP_HEIGHT:  cfg.map_height          <= cfg_data;
        REG_OUTSIDE:     cfg.outside_is_obstacle <= cfg_data[0];
        default: ;
      endcase
    end
  end

  gfcc_trig #(
    .ANGLE_STEPS (ANGLE_STEPS)
  ) u_trig (
    .clk     (clk),
    .rst     (rst),
    .start   (query_take),
    .heading (heading),
    .trig    (trig)
  );

  gfcc_map_mem #(
    .MAP_SIDE       (MAP_SIDE),
    .OCCUPANCY_BITS (OCCUPANCY_BITS)
  ) u_map_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // loads only happen while the walker is idle, so a map write never
  // meets a read of the same cell
  gfcc_walker #(
    .MAP_SIDE       (MAP_SIDE),
    .OCCUPANCY_BITS (OCCUPANCY_BITS)
  ) u_walker (
    .clk     (clk),
    .rst     (rst),
    .start   (query_take),
    .pose_x  (pose_x),
    .pose_y  (pose_y),
    .cfg     (cfg),
    .trig    (trig),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .res     (res),
    .res_ack (res_ack)
  );

  assign res_ack       = res.done && out_free;
  assign res_collision = (res.status == ST_OBSTACLE)
                      || ((res.status == ST_OUTSIDE) && cfg.outside_is_obstacle);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_take || res_ack) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (load_take) begin
      status    <= ST_FREE;
      collision <= 1'b0;
    end else if (res_ack) begin
      status    <= res.status;
      collision <= res_collision;
    end
  end

  // a load transaction shows its result in the next cycle
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    load_take |=> out_valid && status == ST_FREE && !collision)
    else $error("load transaction gave no clean result");

  // nothing is taken in while a query is in progress
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    res.busy |-> in_stall)
    else $error("input taken during a query");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(collision))
    else $error("result changed while stalled");

endmodule

`default_nettype wire
